// ----- hw/rtl/spq_pkg.sv -----
// Shared constants, types and op codes of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int PRI_W    = 8;
	localparam int PAY_W    = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int IN_BITS     = PAY_W + PRI_W;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 4 * PAY_W + PRI_W + CNT_W + 2;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int MODE_W      = 2;
	localparam int OUT_USER_W  = 2;

	localparam logic [MODE_W-1:0] MODE_ENQ    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REM_LO = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REM_HI = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] pay;
	} entry_t;

	typedef struct packed {
		logic             enq;
		logic             rem_lo;
		logic             rem_hi;
		entry_t           item;
		logic [PRI_W-1:0] top_pri;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts it left or right.
`timescale 1ns / 1ps
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic                occ_right,
	input  spq_pkg::entry_t     left_entry,
	input  spq_pkg::entry_t     right_entry,
	input  logic                g_left,
	input  logic                m_left,
	output spq_pkg::entry_t     entry,
	output logic                g,
	output logic                m,
	output logic                first,
	output logic                last
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	assign entry = entry_q;
	assign g     = !occ || (entry_q.pri > ctrl.item.pri);
	assign m     = occ && (entry_q.pri == ctrl.top_pri);
	assign first = m && !m_left;
	assign last  = occ && !occ_right;

	always_comb begin
		entry_d = entry_q;
		if (ctrl.enq) begin
			if (g_left) begin
				entry_d = left_entry;
			end else if (g) begin
				entry_d = ctrl.item;
			end
		end else if (ctrl.rem_lo) begin
			entry_d = right_entry;
		end else if (ctrl.rem_hi && (m || !occ)) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ----- hw/rtl/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: cell chain, count and result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata payload+priority
//  m_      | out | m_tvalid/m_tready  | m_tuser flags, m_tdata taken entry+status
//
//  An operation updates the cell chain in the cycle it is accepted; its result
//  is formed from the updated chain once the output register is free, and held there.
//  One operation per cycle while the result side takes every transfer.
//  A stalled result lets one more operation into the chain; the input then stalls.
//  arst_n clears the count and the handshake state; slot contents stay unknown.
`timescale 1ns / 1ps
module sorted_priority_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [15:0] item_payload, [23:16] item_priority
	input  logic [spq_pkg::IN_DATA_W-1:0]      s_tdata,
	// [1:0] mode
	input  logic [spq_pkg::MODE_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] taken_payload, [23:16] taken_priority, [28:24] entry_count,
	// [29] is_empty, [30] is_full, [46:31] lowest_payload,
	// [62:47] highest_payload, [78:63] last_payload, [79] zero
	output logic [spq_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] taken_valid, [1] rejected
	output logic [spq_pkg::OUT_USER_W-1:0]     m_tuser
);

	localparam int N = spq_pkg::CAPACITY;

	logic [spq_pkg::CNT_W-1:0] cnt_q;
	logic                      pend_q;
	logic                      m_tvalid_q;
	logic [spq_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [spq_pkg::OUT_USER_W-1:0] m_tuser_q;

	logic                      taken_valid_s1;
	spq_pkg::entry_t           taken_s1;
	logic                      rej_s1;

	spq_pkg::entry_t     ent     [N];
	logic                g_v     [N];
	logic                m_v     [N];
	logic                first_v [N];
	logic                last_v  [N];
	logic                occ_v   [N];
	spq_pkg::cell_ctrl_t ctrl;

	logic                  accept;
	logic                  out_free;
	logic                  summ;
	logic                  full;
	logic                  empty;
	logic [spq_pkg::MODE_W-1:0] mode;
	logic [spq_pkg::PRI_W-1:0]  top_pri;
	spq_pkg::entry_t       hi_ent;
	spq_pkg::entry_t       last_ent;
	spq_pkg::entry_t       lo_ent;
	logic [spq_pkg::CNT_W-1:0] cnt_d;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = !pend_q || out_free;
	assign accept   = s_tvalid && s_tready;
	assign summ     = pend_q && out_free;
	assign full     = (cnt_q == spq_pkg::CNT_W'(N));
	assign empty    = (cnt_q == '0);
	assign mode     = s_tuser;

	always_comb begin
		top_pri  = '0;
		last_ent = '0;
		for (int i = 0; i < N; i++) begin
			if (last_v[i]) begin
				top_pri  = top_pri | ent[i].pri;
				last_ent = last_ent | ent[i];
			end
		end
		lo_ent = occ_v[0] ? ent[0] : '0;
	end

	always_comb begin
		hi_ent = '0;
		for (int i = 0; i < N; i++) begin
			if (first_v[i]) begin
				hi_ent = hi_ent | ent[i];
			end
		end
	end

	always_comb begin
		ctrl.enq      = accept && (mode == spq_pkg::MODE_ENQ) && !full;
		ctrl.rem_lo   = accept && (mode == spq_pkg::MODE_REM_LO) && !empty;
		ctrl.rem_hi   = accept && (mode == spq_pkg::MODE_REM_HI) && !empty;
		ctrl.item.pay = s_tdata[spq_pkg::PAY_W-1:0];
		ctrl.item.pri = s_tdata[spq_pkg::PAY_W +: spq_pkg::PRI_W];
		ctrl.top_pri  = top_pri;
	end

	always_comb begin
		cnt_d = cnt_q;
		if (accept) begin
			case (mode)
				spq_pkg::MODE_ENQ: begin
					if (!full) begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				spq_pkg::MODE_REM_LO, spq_pkg::MODE_REM_HI: begin
					if (!empty) begin
						cnt_d = cnt_q - 1'b1;
					end
				end
				spq_pkg::MODE_CLEAR: begin
					cnt_d = '0;
				end
				default: begin
					cnt_d = cnt_q;
				end
			endcase
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occ_v[i] = (spq_pkg::CNT_W'(i) < cnt_q);
		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occ        (occ_v[i]),
				.occ_right  (occ_v[i+1]),
				.left_entry ('0),
				.right_entry(ent[i+1]),
				.g_left     (1'b0),
				.m_left     (1'b0),
				.entry      (ent[i]),
				.g          (g_v[i]),
				.m          (m_v[i]),
				.first      (first_v[i]),
				.last       (last_v[i])
			);
		end else if (i == N - 1) begin : g_tail
			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occ        (occ_v[i]),
				.occ_right  (1'b0),
				.left_entry (ent[i-1]),
				.right_entry(ent[i]),
				.g_left     (g_v[i-1]),
				.m_left     (m_v[i-1]),
				.entry      (ent[i]),
				.g          (g_v[i]),
				.m          (m_v[i]),
				.first      (first_v[i]),
				.last       (last_v[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occ        (occ_v[i]),
				.occ_right  (occ_v[i+1]),
				.left_entry (ent[i-1]),
				.right_entry(ent[i+1]),
				.g_left     (g_v[i-1]),
				.m_left     (m_v[i-1]),
				.entry      (ent[i]),
				.g          (g_v[i]),
				.m          (m_v[i]),
				.first      (first_v[i]),
				.last       (last_v[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				pend_q <= 1'b1;
			end else if (summ) begin
				pend_q <= 1'b0;
			end
			if (summ) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			taken_valid_s1 <= ctrl.rem_lo || ctrl.rem_hi;
			rej_s1         <= (mode == spq_pkg::MODE_ENQ) && full;
			if (ctrl.rem_lo) begin
				taken_s1 <= ent[0];
			end else if (ctrl.rem_hi) begin
				taken_s1 <= hi_ent;
			end else begin
				taken_s1 <= '0;
			end
		end
		if (summ) begin
			m_tuser_q <= {rej_s1, taken_valid_s1};
			m_tdata_q <= spq_pkg::OUT_DATA_W'({last_ent.pay, hi_ent.pay, lo_ent.pay,
				full, empty, cnt_q, taken_s1.pri, taken_s1.pay});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- hw/rtl/spq_checker.sv -----
// Port-level checks of the sorted priority queue and their binding.
`timescale 1ns / 1ps
module spq_port_checks (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [spq_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [spq_pkg::OUT_USER_W-1:0] m_tuser
);

	logic [spq_pkg::CNT_W-1:0] cnt;
	logic                      empty;
	logic                      full;
	logic [spq_pkg::PAY_W-1:0] lo_pay;
	logic [spq_pkg::PAY_W-1:0] hi_pay;
	logic [spq_pkg::PAY_W-1:0] last_pay;

	assign cnt      = m_tdata[spq_pkg::PAY_W + spq_pkg::PRI_W +: spq_pkg::CNT_W];
	assign empty    = m_tdata[spq_pkg::PAY_W + spq_pkg::PRI_W + spq_pkg::CNT_W];
	assign full     = m_tdata[spq_pkg::PAY_W + spq_pkg::PRI_W + spq_pkg::CNT_W + 1];
	assign lo_pay   = m_tdata[spq_pkg::PAY_W + spq_pkg::PRI_W + spq_pkg::CNT_W + 2 +:
		spq_pkg::PAY_W];
	assign hi_pay   = m_tdata[2 * spq_pkg::PAY_W + spq_pkg::PRI_W + spq_pkg::CNT_W + 2 +:
		spq_pkg::PAY_W];
	assign last_pay = m_tdata[3 * spq_pkg::PAY_W + spq_pkg::PRI_W + spq_pkg::CNT_W + 2 +:
		spq_pkg::PAY_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("removal and reject flagged together");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (empty == (cnt == '0)) &&
		(full == (cnt == spq_pkg::CNT_W'(spq_pkg::CAPACITY))))
		else $error("empty or full flag disagrees with count");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
		else $error("count beyond capacity");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && empty |-> (lo_pay == '0) && (hi_pay == '0) && (last_pay == '0))
		else $error("payload shown for empty queue");

endmodule

bind sorted_priority_queue_top spq_port_checks u_spq_port_checks (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
